/* hw/rtl/mips_subset_single_cycle_core_top_assert.svh */
// Assertion macros for the MIPS subset core top level.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef MIPS_SUBSET_SINGLE_CYCLE_CORE_TOP_ASSERT_SVH
`define MIPS_SUBSET_SINGLE_CYCLE_CORE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define MSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("core check failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define MSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("core check failed: next-cycle implication");
`else
`define MSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MSC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/msc_pkg.sv */
// Shared constants, types and helpers for the MIPS subset core.
// Used by every module of the core; depends on nothing.
package msc_pkg;

    localparam int DMEM_WORDS = 16384;
    localparam int DMEM_AW    = $clog2(DMEM_WORDS);
    localparam int NUM_REGS   = 32;
    localparam int REG_AW     = 5;
    localparam int LOAD_IDX_W = 14;

    // Primary opcodes.
    localparam logic [5:0] OPC_RTYPE = 6'h00;
    localparam logic [5:0] OPC_J     = 6'h02;
    localparam logic [5:0] OPC_BEQ   = 6'h04;
    localparam logic [5:0] OPC_ADDIU = 6'h09;
    localparam logic [5:0] OPC_LW    = 6'd35;
    localparam logic [5:0] OPC_SW    = 6'd43;
    localparam logic [5:0] OPC_HALT  = 6'd63;

    // R-type function codes.
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;

    // Item operations.
    localparam logic OP_EXEC    = 1'b0;
    localparam logic OP_PRELOAD = 1'b1;

    typedef struct packed {
        logic [31:0]       next_pc;
        logic              halted;
        logic              reg_written;
        logic [REG_AW-1:0] reg_index;
        logic [31:0]       reg_value;
        logic              load_pending;
        logic              mem_written;
        logic [31:0]       mem_address;
        logic [31:0]       mem_value;
        logic              misaligned;
    } t_result;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [DMEM_AW-1:0] idx;
        logic [31:0]        wdata;
    } t_dmem_req;

    typedef struct packed {
        logic              we;
        logic [REG_AW-1:0] idx;
        logic [31:0]       data;
    } t_rf_wr;

    function automatic logic [31:0] sign_ext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

/* hw/rtl/mips_subset_single_cycle_core_top.sv */
// Top level of the MIPS subset core: pipeline registers, forwarding and state.
// Depends on msc_pkg, msc_regfile, msc_dmem, msc_exec and the assertion header.
//
//  Channel  Valid    Stall    Word
//  -------  -------  -------  ------------------------------------------------
//  in       i_valid  o_stall  i_op, i_instr, i_load_index, i_load_value
//  out      o_valid  i_stall  o_next_pc, o_halted, o_reg_*, o_mem_*, o_misaligned
//
// A word is accepted at a rising edge where valid is high and stall is low.
// Each word passes through execute and memory/writeback and then sits in the
// output register, which drives its result; a new word is taken every cycle unless
// a stall holds the pipeline, set by the single data memory port (one access a word).
// After reset the data memory is cleared one word a cycle: o_stall stays high until
// all 16384 words (DMEM_WORDS) are cleared, and only then is the first word taken.
// A stall on the output freezes the whole pipeline, so o_stall follows i_stall
// whenever a result is waiting in the output register.
`include "mips_subset_single_cycle_core_top_assert.svh"

module mips_subset_single_cycle_core_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_op,
    input  logic [31:0]                     i_instr,
    input  logic [msc_pkg::LOAD_IDX_W-1:0]  i_load_index,
    input  logic [31:0]                     i_load_value,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [31:0]                     o_next_pc,
    output logic                            o_halted,
    output logic                            o_reg_written,
    output logic [msc_pkg::REG_AW-1:0]      o_reg_index,
    output logic [31:0]                     o_reg_value,
    output logic                            o_mem_written,
    output logic [31:0]                     o_mem_address,
    output logic [31:0]                     o_mem_value,
    output logic                            o_misaligned
);
    import msc_pkg::*;

    // Pipeline advance: every stage moves together unless a result is held up
    // at the output. Relative positions of words therefore never change, which
    // keeps the forwarding sources fixed.
    logic      en;
    logic      accept;
    logic      dmem_busy;
    logic [31:0] dmem_q;

    // Execute stage.
    logic                  r_b_valid;
    logic                  r_b_op;
    logic [31:0]           r_b_instr;
    logic [LOAD_IDX_W-1:0] r_b_load_index;
    logic [31:0]           r_b_load_value;

    // Architectural program counter and halt flag.
    logic [31:0] r_pc;
    logic        r_halt;

    // Memory/writeback stage and output register.
    logic    r_c_valid;
    t_result r_c;
    logic    r_o_valid;
    t_result r_o;

    logic [31:0] rf_a;
    logic [31:0] rf_b;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] c_val;
    t_result     c_fin;
    t_result     ex_res;
    t_dmem_req   ex_req;
    t_dmem_req   dmem_req;
    t_rf_wr      rf_wr;

    assign en      = !(r_o_valid && i_stall);
    assign o_stall = !en || dmem_busy;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_pc      <= '0;
            r_halt    <= 1'b0;
        end else if (en) begin
            r_b_valid <= accept;
            r_c_valid <= r_b_valid;
            r_o_valid <= r_c_valid;
            if (r_b_valid) begin
                r_pc   <= ex_res.next_pc;
                r_halt <= ex_res.halted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_op         <= i_op;
            r_b_instr      <= i_instr;
            r_b_load_index <= i_load_index;
            r_b_load_value <= i_load_value;
            r_c            <= ex_res;
            r_o            <= c_fin;
        end
    end

    // The register file is read as the word enters execute, using the source
    // fields straight from the input port.
    msc_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (en),
        .i_rd_addr_a (i_instr[25:21]),
        .i_rd_addr_b (i_instr[20:16]),
        .i_wr        (rf_wr),
        .o_rd_a      (rf_a),
        .o_rd_b      (rf_b)
    );

    // A load's value comes out of the data memory while the word is in the
    // writeback stage; everything else was worked out in execute.
    assign c_val = r_c.load_pending ? dmem_q : r_c.reg_value;

    always_comb begin
        c_fin           = r_c;
        c_fin.reg_value = c_val;
    end

    // Forwarding into execute. The word in writeback has not yet written the
    // register file; the word in the output register wrote it at the same edge
    // at which the file was read, so the read returned the old value.
    always_comb begin
        if (r_c_valid && r_c.reg_written && r_c.reg_index == r_b_instr[25:21]) begin
            op_a = c_val;
        end else if (r_o_valid && r_o.reg_written && r_o.reg_index == r_b_instr[25:21]) begin
            op_a = r_o.reg_value;
        end else begin
            op_a = rf_a;
        end
        if (r_c_valid && r_c.reg_written && r_c.reg_index == r_b_instr[20:16]) begin
            op_b = c_val;
        end else if (r_o_valid && r_o.reg_written && r_o.reg_index == r_b_instr[20:16]) begin
            op_b = r_o.reg_value;
        end else begin
            op_b = rf_b;
        end
    end

    msc_exec u_exec (
        .i_op         (r_b_op),
        .i_instr      (r_b_instr),
        .i_load_index (r_b_load_index),
        .i_load_value (r_b_load_value),
        .i_pc         (r_pc),
        .i_halted     (r_halt),
        .i_a          (op_a),
        .i_b          (op_b),
        .o_res        (ex_res),
        .o_req        (ex_req)
    );

    // Memory side effects happen only when the word really leaves execute.
    always_comb begin
        dmem_req    = ex_req;
        dmem_req.we = ex_req.we && r_b_valid && en;
        dmem_req.re = ex_req.re && r_b_valid && en;
    end

    msc_dmem u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (dmem_req),
        .o_rd_data (dmem_q),
        .o_busy    (dmem_busy)
    );

    always_comb begin
        rf_wr.we   = en && r_c_valid && r_c.reg_written;
        rf_wr.idx  = r_c.reg_index;
        rf_wr.data = c_val;
    end

    assign o_valid       = r_o_valid;
    assign o_next_pc     = r_o.next_pc;
    assign o_halted      = r_o.halted;
    assign o_reg_written = r_o.reg_written;
    assign o_reg_index   = r_o.reg_index;
    assign o_reg_value   = r_o.reg_value;
    assign o_mem_written = r_o.mem_written;
    assign o_mem_address = r_o.mem_address;
    assign o_mem_value   = r_o.mem_value;
    assign o_misaligned  = r_o.misaligned;

    // Register zero must never be written, or it would stop reading as zero.
    `MSC_ASSERT_IMP(a_no_r0_write, i_clk, i_rst_n, rf_wr.we, rf_wr.idx != '0)
    // Once set, the halt flag stays set until reset.
    `MSC_ASSERT_NXT(a_halt_sticky, i_clk, i_rst_n, r_halt, r_halt)
    // The data memory has a single port: never a read and a write together.
    `MSC_ASSERT_IMP(a_dmem_one_access, i_clk, i_rst_n, dmem_req.we, !dmem_req.re)
    // A halted core must leave the data memory untouched.
    `MSC_ASSERT_IMP(a_halted_no_store, i_clk, i_rst_n, r_halt && r_b_valid, !dmem_req.we)

endmodule

/* hw/rtl/msc_regfile.sv */
// 32-entry register file with two registered read ports and one write port.
// Depends on msc_pkg; unwritten entries read as zero through per-entry valid bits.
module msc_regfile (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [msc_pkg::REG_AW-1:0]    i_rd_addr_a,
    input  logic [msc_pkg::REG_AW-1:0]    i_rd_addr_b,
    input  msc_pkg::t_rf_wr               i_wr,
    output logic [31:0]                   o_rd_a,
    output logic [31:0]                   o_rd_b
);
    import msc_pkg::*;

    logic [31:0]         r_mem [0:NUM_REGS-1];
    logic [NUM_REGS-1:0] r_vld;
    logic [31:0]         r_q_a;
    logic [31:0]         r_q_b;
    logic                r_qv_a;
    logic                r_qv_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_q_a <= r_mem[i_rd_addr_a];
            r_q_b <= r_mem[i_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_qv_a <= 1'b0;
            r_qv_b <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_vld[i_wr.idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_qv_a <= r_vld[i_rd_addr_a];
                r_qv_b <= r_vld[i_rd_addr_b];
            end
        end
    end

    assign o_rd_a = r_qv_a ? r_q_a : '0;
    assign o_rd_b = r_qv_b ? r_q_b : '0;

endmodule

/* hw/rtl/msc_dmem.sv */
// Single-port word data memory with a registered read and a clearing pass after reset.
// Depends on msc_pkg for its depth and request type.
module msc_dmem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msc_pkg::t_dmem_req i_req,
    output logic [31:0]        o_rd_data,
    output logic               o_busy
);
    import msc_pkg::*;

    logic [31:0]        r_mem [0:DMEM_WORDS-1];
    logic [31:0]        r_q;
    logic               r_clr_busy;
    logic [DMEM_AW-1:0] r_clr_idx;

    // The clearing pass walks every word once, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == DMEM_AW'(DMEM_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_req.we) begin
            r_mem[i_req.idx] <= i_req.wdata;
        end
        if (!r_clr_busy && i_req.re) begin
            r_q <= r_mem[i_req.idx];
        end
    end

    assign o_rd_data = r_q;
    assign o_busy    = r_clr_busy;

endmodule

/* hw/rtl/msc_exec.sv */
// Decode and execute logic for one word: ALU, branch and jump target, memory request.
// Depends on msc_pkg; purely combinational, operands arrive already forwarded.
module msc_exec (
    input  logic                              i_op,
    input  logic [31:0]                       i_instr,
    input  logic [msc_pkg::LOAD_IDX_W-1:0]    i_load_index,
    input  logic [31:0]                       i_load_value,
    input  logic [31:0]                       i_pc,
    input  logic                              i_halted,
    input  logic [31:0]                       i_a,
    input  logic [31:0]                       i_b,
    output msc_pkg::t_result                  o_res,
    output msc_pkg::t_dmem_req                o_req
);
    import msc_pkg::*;

    logic [5:0]        opcode;
    logic [5:0]        funct;
    logic [REG_AW-1:0] rt;
    logic [REG_AW-1:0] rd;
    logic [31:0]       imm;
    logic [31:0]       pc4;
    logic [31:0]       ea;
    logic              ea_mis;
    logic [31:0]       alu_val;
    logic              wr;
    logic [REG_AW-1:0] dest;
    logic [31:0]       val;
    logic              is_lw;

    assign opcode = i_instr[31:26];
    assign funct  = i_instr[5:0];
    assign rt     = i_instr[20:16];
    assign rd     = i_instr[15:11];
    assign imm    = sign_ext16(i_instr[15:0]);
    assign pc4    = i_pc + 32'd4;
    assign ea     = i_a + imm;
    assign ea_mis = |ea[1:0];

    always_comb begin
        unique case (funct)
            FN_ADDU: alu_val = i_a + i_b;
            FN_SUBU: alu_val = i_a - i_b;
            FN_AND:  alu_val = i_a & i_b;
            FN_OR:   alu_val = i_a | i_b;
            FN_NOR:  alu_val = ~(i_a | i_b);
            default: alu_val = '0;
        endcase
    end

    always_comb begin
        o_res         = '0;
        o_req         = '0;
        o_res.next_pc = i_pc;
        wr            = 1'b0;
        dest          = '0;
        val           = '0;
        is_lw         = 1'b0;
        if (!i_halted) begin
            if (i_op == OP_PRELOAD) begin
                o_req.we    = 1'b1;
                o_req.idx   = DMEM_AW'({{DMEM_AW{1'b0}}, i_load_index});
                o_req.wdata = i_load_value;
            end else begin
                o_res.next_pc = pc4;
                unique case (opcode)
                    OPC_HALT: begin
                        o_res.halted  = 1'b1;
                        o_res.next_pc = i_pc;
                    end
                    OPC_RTYPE: begin
                        wr   = 1'b1;
                        dest = rd;
                        val  = alu_val;
                    end
                    OPC_J: begin
                        o_res.next_pc = {pc4[31:28], i_instr[25:0], 2'b00};
                    end
                    OPC_BEQ: begin
                        if (i_a == i_b) begin
                            o_res.next_pc = pc4 + {imm[29:0], 2'b00};
                        end
                    end
                    OPC_ADDIU: begin
                        wr   = 1'b1;
                        dest = rt;
                        val  = ea;
                    end
                    OPC_LW: begin
                        o_res.mem_address = ea;
                        o_res.misaligned  = ea_mis;
                        wr                = 1'b1;
                        dest              = rt;
                        is_lw             = !ea_mis;
                        o_req.re          = !ea_mis;
                        o_req.idx         = ea[DMEM_AW+1:2];
                    end
                    OPC_SW: begin
                        o_res.mem_address = ea;
                        o_res.misaligned  = ea_mis;
                        if (!ea_mis) begin
                            o_res.mem_written = 1'b1;
                            o_res.mem_value   = i_b;
                            o_req.we          = 1'b1;
                            o_req.idx         = ea[DMEM_AW+1:2];
                            o_req.wdata       = i_b;
                        end
                    end
                    default: begin
                    end
                endcase
                if (wr && dest != '0) begin
                    o_res.reg_written  = 1'b1;
                    o_res.reg_index    = dest;
                    o_res.reg_value    = val;
                    o_res.load_pending = is_lw;
                end
            end
        end
        o_res.halted = o_res.halted | i_halted;
    end

endmodule
